// ===== design/framebuffer_fill_and_alpha_blit_assert.svh =====
// Assertion macros used by the checking file of the blitter (ffab_monitor).
`ifndef FRAMEBUFFER_FILL_AND_ALPHA_BLIT_ASSERT_SVH
`define FRAMEBUFFER_FILL_AND_ALPHA_BLIT_ASSERT_SVH

// same-cycle implication
`define FFAB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFAB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ffab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffab_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam int ACT_W  = 3;
   localparam int POS_W  = 16;
   localparam int SIZE_W = 12;
   localparam int PIX_W  = 32;
   localparam int STAT_W = 2;
   localparam int WIN_W  = 9;
   localparam int PROD_W = 2 * WIN_W;
   localparam int SUM_W  = 16;
   localparam int CRD_W  = 18;

   localparam logic [ACT_W-1:0] ACT_FILL  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd1;
   localparam logic [ACT_W-1:0] ACT_START = 3'd2;
   localparam logic [ACT_W-1:0] ACT_PIXEL = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] ST_CLIP   = 2'd1;
   localparam logic [STAT_W-1:0] ST_SKIP   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOBLIT = 2'd3;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [WIN_W-1:0] WIN_RESET = 9'd256;
   localparam logic [7:0]       ALPHA_MAX = 8'hFF;
   localparam logic [7:0]       ALPHA_MIN = 8'h00;

   typedef enum logic [2:0] {
      OP_FILL, OP_CLEAR, OP_START, OP_PIXEL, OP_READ, OP_NONE
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [SIZE_W-1:0]        size_w;
      logic [SIZE_W-1:0]        size_h;
      logic [PIX_W-1:0]         color;
   } cmd_type;

   // floor(v / 255) for v below 65280
   function automatic logic [7:0] div255(input logic [SUM_W-1:0] v);
      logic [SUM_W:0] t;
      t = (SUM_W+1)'(v) + (SUM_W+1)'(1) + (SUM_W+1)'(v[SUM_W-1:8]);
      return t[SUM_W-1:8];
   endfunction

endpackage
`default_nettype wire

// ===== design/ffab_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffab_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ffab_pkg::ACT_W-1:0]        req_action,
   input  wire logic signed [ffab_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [ffab_pkg::POS_W-1:0] req_pos_y,
   input  wire logic [ffab_pkg::SIZE_W-1:0]       req_size_w,
   input  wire logic [ffab_pkg::SIZE_W-1:0]       req_size_h,
   input  wire logic [ffab_pkg::PIX_W-1:0]        req_color,
   input  wire logic                              init_busy,
   input  wire logic                              cmd_pop,
   output logic                                   cmd_valid,
   output ffab_pkg::cmd_type                      cmd
);

   ffab_pkg::cmd_type q_ff [2];
   ffab_pkg::cmd_type entry_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   always_comb begin
      case (req_action)
         ffab_pkg::ACT_FILL:  entry_in.op = ffab_pkg::OP_FILL;
         ffab_pkg::ACT_CLEAR: entry_in.op = ffab_pkg::OP_CLEAR;
         ffab_pkg::ACT_START: entry_in.op = ffab_pkg::OP_START;
         ffab_pkg::ACT_PIXEL: entry_in.op = ffab_pkg::OP_PIXEL;
         ffab_pkg::ACT_READ:  entry_in.op = ffab_pkg::OP_READ;
         default:             entry_in.op = ffab_pkg::OP_NONE;
      endcase
      entry_in.pos_x  = req_pos_x;
      entry_in.pos_y  = req_pos_y;
      entry_in.size_w = req_size_w;
      entry_in.size_h = req_size_h;
      entry_in.color  = req_color;
   end

   assign req_stall = (count_ff == 2'd2) || init_busy;
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/ffab_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffab_back #(
   parameter int MAX_WIDTH  = ffab_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ffab_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   input  wire ffab_pkg::cmd_type             cmd,
   output logic                               cmd_pop,
   output logic                               init_busy,
   input  wire logic [ffab_pkg::WIN_W-1:0]    win_w,
   input  wire logic [ffab_pkg::WIN_W-1:0]    win_h,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ffab_pkg::PIX_W-1:0]         rsp_read_data,
   output logic [ffab_pkg::STAT_W-1:0]        rsp_status,
   output logic                               rsp_blit_last
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = ffab_pkg::WIN_W;
   localparam int PW    = ffab_pkg::PROD_W;
   localparam int CW    = ffab_pkg::CRD_W;
   localparam int SW    = ffab_pkg::SIZE_W;
   localparam int XW    = ffab_pkg::PIX_W;
   localparam int UW    = ffab_pkg::SUM_W;
   localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_FILL_CLIP = 4'd2;
   localparam logic [3:0] S_FILL_ROW  = 4'd3;
   localparam logic [3:0] S_FILL_RUN  = 4'd4;
   localparam logic [3:0] S_CLEAR     = 4'd5;
   localparam logic [3:0] S_PIX_POS   = 4'd6;
   localparam logic [3:0] S_PIX_ADDR  = 4'd7;
   localparam logic [3:0] S_PIX_WAIT  = 4'd8;
   localparam logic [3:0] S_PIX_MUL   = 4'd9;
   localparam logic [3:0] S_PIX_WRITE = 4'd10;
   localparam logic [3:0] S_RD_POS    = 4'd11;
   localparam logic [3:0] S_RESP      = 4'd12;

   logic [XW-1:0] mem [DEPTH];

   logic [3:0]               state_ff, state_in;
   ffab_pkg::cmd_type        cmd_ff, cmd_in;
   logic [AW-1:0]            init_ff, init_in;
   logic [PW-1:0]            clr_ff, clr_in;
   logic [PW-1:0]            clr_last_ff, clr_last_in;
   logic [WW-1:0]            x_ff, x_in, y_ff, y_in;
   logic [WW-1:0]            x0_ff, x0_in, xl_ff, xl_in, yl_ff, yl_in;
   logic [PW-1:0]            row_ff, row_in;
   logic signed [15:0]       box_ff, box_in, boy_ff, boy_in;
   logic [SW-1:0]            bw_ff, bw_in, bh_ff, bh_in;
   logic [SW-1:0]            col_ff, col_in, rcnt_ff, rcnt_in;
   logic                     active_ff, active_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [XW-1:0]            rdata_ff;
   logic [XW-1:0]            bg_ff, bg_in;
   logic [UW-1:0]            sr_ff, sr_in, sg_ff, sg_in, sb_ff, sb_in;
   logic                     rv_ff, rv_in;
   logic [XW-1:0]            rd_ff, rd_in;
   logic [1:0]               rs_ff, rs_in;
   logic                     rl_ff, rl_in;

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [XW-1:0]            mem_wdata;

   logic signed [CW-1:0]     fx0, fy0, fx1, fy1, cx0, cy0, cx1, cy1, wws, whs;
   logic signed [CW-1:0]     bx, by;
   logic                     clipped, empty_size, nonempty, in_win;
   logic [7:0]               alpha, inv;
   logic [XW-1:0]            blended;

   assign init_busy     = (state_ff == S_INIT);
   assign rsp_valid     = rv_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_status    = rs_ff;
   assign rsp_blit_last = rl_ff;

   always_comb begin
      wws = $signed(CW'(win_w));
      whs = $signed(CW'(win_h));
      fx0 = CW'(cmd_ff.pos_x);
      fy0 = CW'(cmd_ff.pos_y);
      fx1 = fx0 + $signed(CW'(cmd_ff.size_w));
      fy1 = fy0 + $signed(CW'(cmd_ff.size_h));
      clipped    = (fx0 < 0) || (fy0 < 0) || (fx1 > wws) || (fy1 > whs);
      cx0        = (fx0 < 0) ? '0 : fx0;
      cy0        = (fy0 < 0) ? '0 : fy0;
      cx1        = (fx1 > wws) ? wws : fx1;
      cy1        = (fy1 > whs) ? whs : fy1;
      empty_size = (cmd_ff.size_w == '0) || (cmd_ff.size_h == '0);
      nonempty   = !empty_size && (cx0 < cx1) && (cy0 < cy1);

      if (state_ff == S_RD_POS) begin
         bx = CW'(cmd_ff.pos_x);
         by = CW'(cmd_ff.pos_y);
      end else begin
         bx = CW'(box_ff) + $signed(CW'(col_ff));
         by = CW'(boy_ff) + $signed(CW'(rcnt_ff));
      end
      in_win = (bx >= 0) && (by >= 0) && (bx < wws) && (by < whs);

      alpha   = cmd_ff.color[31:24];
      inv     = ffab_pkg::ALPHA_MAX - alpha;
      blended = {ffab_pkg::ALPHA_MAX, ffab_pkg::div255(sr_ff),
                 ffab_pkg::div255(sg_ff), ffab_pkg::div255(sb_ff)};
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      init_in     = init_ff;
      clr_in      = clr_ff;
      clr_last_in = clr_last_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      x0_in       = x0_ff;
      xl_in       = xl_ff;
      yl_in       = yl_ff;
      row_in      = row_ff;
      box_in      = box_ff;
      boy_in      = boy_ff;
      bw_in       = bw_ff;
      bh_in       = bh_ff;
      col_in      = col_ff;
      rcnt_in     = rcnt_ff;
      active_in   = active_ff;
      addr_in     = addr_ff;
      bg_in       = bg_ff;
      sr_in       = sr_ff;
      sg_in       = sg_ff;
      sb_in       = sb_ff;
      rv_in       = rv_ff;
      rd_in       = rd_ff;
      rs_in       = rs_ff;
      rl_in       = rl_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = addr_ff;
      mem_wdata   = cmd_ff.color;

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_ff;
            mem_wdata = '0;
            init_in   = init_ff + AW'(1);
            if (init_ff == LastAddr) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               rd_in   = '0;
               rs_in   = ffab_pkg::ST_DONE;
               rl_in   = 1'b0;
               case (cmd.op)
                  ffab_pkg::OP_FILL: state_in = S_FILL_CLIP;
                  ffab_pkg::OP_CLEAR: begin
                     clr_in      = '0;
                     clr_last_in = PW'(win_w) * PW'(win_h) - PW'(1);
                     state_in    = S_CLEAR;
                  end
                  ffab_pkg::OP_START: begin
                     box_in    = cmd.pos_x;
                     boy_in    = cmd.pos_y;
                     bw_in     = cmd.size_w;
                     bh_in     = cmd.size_h;
                     col_in    = '0;
                     rcnt_in   = '0;
                     active_in = (cmd.size_w != '0) && (cmd.size_h != '0);
                     rv_in     = 1'b1;
                     state_in  = S_RESP;
                  end
                  ffab_pkg::OP_PIXEL: begin
                     if (active_ff) begin
                        state_in = S_PIX_POS;
                     end else begin
                        rs_in    = ffab_pkg::ST_NOBLIT;
                        rv_in    = 1'b1;
                        state_in = S_RESP;
                     end
                  end
                  ffab_pkg::OP_READ: state_in = S_RD_POS;
                  default: begin
                     rv_in    = 1'b1;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_FILL_CLIP: begin
            rs_in = (!empty_size && clipped) ? ffab_pkg::ST_CLIP : ffab_pkg::ST_DONE;
            x0_in = cx0[WW-1:0];
            x_in  = cx0[WW-1:0];
            y_in  = cy0[WW-1:0];
            xl_in = WW'(cx1 - CW'(1));
            yl_in = WW'(cy1 - CW'(1));
            if (nonempty) begin
               state_in = S_FILL_ROW;
            end else begin
               rv_in    = 1'b1;
               state_in = S_RESP;
            end
         end
         S_FILL_ROW: begin
            row_in   = PW'(y_ff) * PW'(win_w);
            state_in = S_FILL_RUN;
         end
         S_FILL_RUN: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(row_ff + PW'(x_ff));
            if (x_ff == xl_ff) begin
               x_in = x0_ff;
               if (y_ff == yl_ff) begin
                  rv_in    = 1'b1;
                  state_in = S_RESP;
               end else begin
                  y_in   = y_ff + WW'(1);
                  row_in = row_ff + PW'(win_w);
               end
            end else begin
               x_in = x_ff + WW'(1);
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(clr_ff);
            clr_in    = clr_ff + PW'(1);
            if (clr_ff == clr_last_ff) begin
               rv_in    = 1'b1;
               state_in = S_RESP;
            end
         end
         S_PIX_POS: begin
            x_in = bx[WW-1:0];
            y_in = by[WW-1:0];
            if ((13'(col_ff) + 13'd1) >= 13'(bw_ff)) begin
               col_in = '0;
               if ((13'(rcnt_ff) + 13'd1) >= 13'(bh_ff)) begin
                  rcnt_in   = '0;
                  active_in = 1'b0;
                  rl_in     = 1'b1;
               end else begin
                  rcnt_in = rcnt_ff + SW'(1);
               end
            end else begin
               col_in = col_ff + SW'(1);
            end
            if (in_win) begin
               state_in = S_PIX_ADDR;
            end else begin
               rs_in    = ffab_pkg::ST_CLIP;
               rv_in    = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RD_POS: begin
            x_in = bx[WW-1:0];
            y_in = by[WW-1:0];
            if (in_win) begin
               state_in = S_PIX_ADDR;
            end else begin
               rs_in    = ffab_pkg::ST_CLIP;
               rv_in    = 1'b1;
               state_in = S_RESP;
            end
         end
         S_PIX_ADDR: begin
            addr_in  = AW'(PW'(y_ff) * PW'(win_w) + PW'(x_ff));
            state_in = S_PIX_WAIT;
         end
         S_PIX_WAIT: begin
            state_in = S_PIX_MUL;
         end
         S_PIX_MUL: begin
            bg_in = rdata_ff;
            sr_in = UW'(cmd_ff.color[23:16]) * UW'(alpha) + UW'(rdata_ff[23:16]) * UW'(inv);
            sg_in = UW'(cmd_ff.color[15:8]) * UW'(alpha) + UW'(rdata_ff[15:8]) * UW'(inv);
            sb_in = UW'(cmd_ff.color[7:0]) * UW'(alpha) + UW'(rdata_ff[7:0]) * UW'(inv);
            if (cmd_ff.op == ffab_pkg::OP_READ) begin
               rd_in    = rdata_ff;
               rv_in    = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_PIX_WRITE;
            end
         end
         S_PIX_WRITE: begin
            if (alpha == ffab_pkg::ALPHA_MAX) begin
               mem_we = 1'b1;
               rd_in  = cmd_ff.color;
            end else if (alpha == ffab_pkg::ALPHA_MIN) begin
               rs_in = ffab_pkg::ST_SKIP;
               rd_in = bg_ff;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = blended;
               rd_in     = blended;
            end
            rv_in    = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rv_in    = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      clr_ff      <= clr_in;
      clr_last_ff <= clr_last_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x0_ff       <= x0_in;
      xl_ff       <= xl_in;
      yl_ff       <= yl_in;
      row_ff      <= row_in;
      addr_ff     <= addr_in;
      bg_ff       <= bg_in;
      sr_ff       <= sr_in;
      sg_ff       <= sg_in;
      sb_ff       <= sb_in;
      rd_ff       <= rd_in;
      rs_ff       <= rs_in;
      rl_ff       <= rl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         init_ff   <= '0;
         box_ff    <= '0;
         boy_ff    <= '0;
         bw_ff     <= '0;
         bh_ff     <= '0;
         col_ff    <= '0;
         rcnt_ff   <= '0;
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         init_ff   <= init_in;
         box_ff    <= box_in;
         boy_ff    <= boy_in;
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
         col_ff    <= col_in;
         rcnt_ff   <= rcnt_in;
         active_ff <= active_in;
         rv_ff     <= rv_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/framebuffer_fill_and_alpha_blit.sv =====
// channel | valid   | stall   | payload
// req     | req_valid | req_stall | action, pos_x, pos_y, size_w, size_h, color
// rsp     | rsp_valid | rsp_stall | read_data, status, blit_last
// csr     | csr_wr_en | -         | csr_index, csr_wr_data
// After reset the frame store is swept to zero while req is stalled.
// Blit pixel: position check, address, frame store read, blend, then write and result;
// read: the same without the write; start blit and unused actions go straight to the result.
// Fill clips its rectangle and writes what is left row by row; clear writes every window pixel.
// A two-deep queue takes requests while the back end works on a command.
// A result waits in its register until rsp_stall is low.
`timescale 1ns / 1ps
`default_nettype none
module framebuffer_fill_and_alpha_blit #(
   parameter int MAX_WIDTH  = ffab_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ffab_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ffab_pkg::ACT_W-1:0]        req_action,
   input  wire logic signed [ffab_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [ffab_pkg::POS_W-1:0] req_pos_y,
   input  wire logic [ffab_pkg::SIZE_W-1:0]       req_size_w,
   input  wire logic [ffab_pkg::SIZE_W-1:0]       req_size_h,
   input  wire logic [ffab_pkg::PIX_W-1:0]        req_color,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [ffab_pkg::PIX_W-1:0]             rsp_read_data,
   output logic [ffab_pkg::STAT_W-1:0]            rsp_status,
   output logic                                   rsp_blit_last,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_index,
   input  wire logic [ffab_pkg::WIN_W-1:0]        csr_wr_data
);

   localparam int WW = ffab_pkg::WIN_W;
   localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
   localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

   logic [WW-1:0]     win_w_ff, win_w_in, win_h_ff, win_h_in;
   logic [WW-1:0]     eff_w, eff_h;
   logic              init_busy;
   logic              cmd_pop;
   logic              cmd_valid;
   ffab_pkg::cmd_type cmd;

   always_comb begin
      win_w_in = win_w_ff;
      win_h_in = win_h_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ffab_pkg::REG_WIDTH:  win_w_in = csr_wr_data;
            ffab_pkg::REG_HEIGHT: win_h_in = csr_wr_data;
            default: ;
         endcase
      end
      if (win_w_ff == '0) begin
         eff_w = WW'(1);
      end else if (13'(win_w_ff) > MaxW) begin
         eff_w = MaxW[WW-1:0];
      end else begin
         eff_w = win_w_ff;
      end
      if (win_h_ff == '0) begin
         eff_h = WW'(1);
      end else if (13'(win_h_ff) > MaxH) begin
         eff_h = MaxH[WW-1:0];
      end else begin
         eff_h = win_h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_w_ff <= ffab_pkg::WIN_RESET;
         win_h_ff <= ffab_pkg::WIN_RESET;
      end else begin
         win_w_ff <= win_w_in;
         win_h_ff <= win_h_in;
      end
   end

   ffab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_size_w (req_size_w),
      .req_size_h (req_size_h),
      .req_color  (req_color),
      .init_busy  (init_busy),
      .cmd_pop    (cmd_pop),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   ffab_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .init_busy     (init_busy),
      .win_w         (eff_w),
      .win_h         (eff_h),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status),
      .rsp_blit_last (rsp_blit_last)
   );

endmodule
`default_nettype wire

// ===== design/ffab_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_fill_and_alpha_blit_assert.svh"
module ffab_monitor (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [ffab_pkg::PIX_W-1:0]     rsp_read_data,
   input wire logic [ffab_pkg::STAT_W-1:0]    rsp_status,
   input wire logic                           rsp_blit_last
);

   `FFAB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")
   `FFAB_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_read_data) && $stable(rsp_status) && $stable(rsp_blit_last), "rsp payload moved")
   `FFAB_ASSERT_IMP(a_noblit_quiet, clock, reset, rsp_valid && rsp_status == ffab_pkg::ST_NOBLIT, rsp_read_data == '0 && !rsp_blit_last, "idle blit pixel not quiet")
   `FFAB_ASSERT_IMP(a_clip_zero, clock, reset, rsp_valid && rsp_status == ffab_pkg::ST_CLIP, rsp_read_data == '0, "clipped transaction carries data")

endmodule

bind framebuffer_fill_and_alpha_blit ffab_monitor u_mon (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_data (rsp_read_data),
   .rsp_status    (rsp_status),
   .rsp_blit_last (rsp_blit_last)
);
`default_nettype wire
